FILE: hw/rtl/fifo_queue_rotate_to_max_macros.svh
// Assertion helpers used by the queue RTL.
`ifndef FIFO_QUEUE_ROTATE_TO_MAX_MACROS_SVH
`define FIFO_QUEUE_ROTATE_TO_MAX_MACROS_SVH

// Same-cycle implication, masked during reset.
`define FQR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, masked during reset.
`define FQR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/fqrm_pkg.sv
package fqrm_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int DATA_W      = 32;
  localparam int ENTRY_W     = 5;

  typedef enum logic [2:0] {
    ACT_INSERT = 3'd0,
    ACT_PEEK   = 3'd1,
    ACT_POP    = 3'd2,
    ACT_ROTATE = 3'd3,
    ACT_CLEAR  = 3'd4
  } action_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic [2:0]               action;
    logic signed [DATA_W-1:0] value;
  } fqrm_req_t;

  typedef struct packed {
    status_t                  status;
    logic signed [DATA_W-1:0] head_value;
    logic [ENTRY_W-1:0]       entry_count;
  } fqrm_rsp_t;

endpackage

FILE: hw/rtl/fifo_queue_rotate_to_max.sv
// Bounded FIFO of signed 32-bit values kept in a ring buffer of QUEUE_DEPTH
// entries. One request on the in_ channel carries a command (insert, peek,
// pop, rotate-largest-to-head, clear) and a value; every request yields one
// response on the out_ channel: status, head value after the command (zero
// when empty) and entry count.
// Flow: insert, peek, pop, clear and unknown commands pass from the
// accepting edge through S_HEAD_RD and S_HEAD_WAIT to out_valid. Rotate
// first scans the queue through the single read port of the ring RAM, one
// entry per cycle, comparing each against the running maximum, and then
// reads the new head. The RAM read port sets the pace; the block takes one
// request at a time and in_ready is low while one is in flight. in_ready
// returns in the same cycle as the response is loaded.
// Rotation only moves the head pointer, cyclic order is kept; ties go to the
// entry closest to the head.
// Reset (rst_n low, synchronous) empties the queue and drops any pending
// response; ring contents are left as they are.
// The response sits in an output register: when the receiver stalls, the
// next request is still accepted and worked on, and its response waits
// in the final step until the register frees up.
module fifo_queue_rotate_to_max
  import fqrm_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  fqrm_req_t in_req,
  output logic      out_valid,
  input  logic      out_ready,
  output fqrm_rsp_t out_rsp
);

  `include "fifo_queue_rotate_to_max_macros.svh"

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_HEAD_RD,
    S_HEAD_WAIT
  } state_t;

  localparam logic [PTR_W:0] DEPTH_WIDE = (PTR_W + 1)'(QUEUE_DEPTH);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);

  function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] base,
                                                input logic [PTR_W-1:0] off);
    logic [PTR_W:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= DEPTH_WIDE) begin
      sum = sum - DEPTH_WIDE;
    end
    return sum[PTR_W-1:0];
  endfunction

  state_t                   state_r, state_nxt;
  logic [PTR_W-1:0]         head_r, head_nxt;
  logic [CNT_W-1:0]         occ_r, occ_nxt;
  status_t                  status_r, status_nxt;
  // scan bookkeeping
  logic [CNT_W-1:0]         iss_r, iss_nxt;      // next offset to read
  logic                     pend_r, pend_nxt;    // read data arrives this cycle
  logic [PTR_W-1:0]         pend_off_r, pend_off_nxt;
  logic [PTR_W-1:0]         best_r, best_nxt;
  logic signed [DATA_W-1:0] max_r, max_nxt;
  // response register
  logic                     out_valid_r, out_valid_nxt;
  fqrm_rsp_t                out_rsp_r, out_rsp_nxt;

  logic                     ram_we;
  logic [PTR_W-1:0]         ram_waddr;
  logic [PTR_W-1:0]         ram_raddr;
  logic [DATA_W-1:0]        ram_rdata;

  fqrm_ram #(
    .WIDTH (DATA_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_req.value),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  assign ram_waddr = wrap_add(head_r, occ_r[PTR_W-1:0]);
  assign ram_raddr = (state_r == S_SCAN) ? wrap_add(head_r, iss_r[PTR_W-1:0]) : head_r;

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    occ_nxt       = occ_r;
    status_nxt    = status_r;
    iss_nxt       = iss_r;
    pend_nxt      = pend_r;
    pend_off_nxt  = pend_off_r;
    best_nxt      = best_r;
    max_nxt       = max_r;
    out_valid_nxt = out_valid_r;
    out_rsp_nxt   = out_rsp_r;
    ram_we        = 1'b0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          status_nxt = ST_OK;
          state_nxt  = S_HEAD_RD;
          unique case (in_req.action)
            ACT_INSERT: begin
              if (occ_r >= DEPTH_CNT) begin
                status_nxt = ST_FULL;
              end else begin
                ram_we  = 1'b1;
                occ_nxt = occ_r + 1'b1;
              end
            end
            ACT_PEEK: begin
              if (occ_r == '0) begin
                status_nxt = ST_EMPTY;
              end
            end
            ACT_POP: begin
              if (occ_r == '0) begin
                status_nxt = ST_EMPTY;
              end else begin
                head_nxt = wrap_add(head_r, PTR_W'(1));
                occ_nxt  = occ_r - 1'b1;
              end
            end
            ACT_ROTATE: begin
              if (occ_r == '0) begin
                status_nxt = ST_EMPTY;
              end else begin
                iss_nxt   = '0;
                pend_nxt  = 1'b0;
                best_nxt  = '0;
                state_nxt = S_SCAN;
              end
            end
            ACT_CLEAR: begin
              head_nxt = '0;
              occ_nxt  = '0;
            end
            default: begin
            end
          endcase
        end
      end

      S_SCAN: begin
        // issue one read per cycle, compare the one that came back
        if (iss_r < occ_r) begin
          iss_nxt      = iss_r + 1'b1;
          pend_nxt     = 1'b1;
          pend_off_nxt = iss_r[PTR_W-1:0];
        end else begin
          pend_nxt = 1'b0;
        end
        if (pend_r) begin
          if (pend_off_r == '0 || $signed(ram_rdata) > max_r) begin
            max_nxt  = $signed(ram_rdata);
            best_nxt = pend_off_r;
          end
        end
        if (!pend_r && iss_r == occ_r) begin
          head_nxt  = wrap_add(head_r, best_r);
          state_nxt = S_HEAD_RD;
        end
      end

      S_HEAD_RD: begin
        state_nxt = S_HEAD_WAIT;
      end

      S_HEAD_WAIT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt           = 1'b1;
          out_rsp_nxt.status      = status_r;
          out_rsp_nxt.head_value  = (occ_r == '0) ? '0 : $signed(ram_rdata);
          out_rsp_nxt.entry_count = ENTRY_W'(occ_r);
          state_nxt               = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      occ_r       <= '0;
      pend_r      <= 1'b0;
      iss_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      occ_r       <= occ_nxt;
      pend_r      <= pend_nxt;
      iss_r       <= iss_nxt;
      out_valid_r <= out_valid_nxt;
    end
    status_r   <= status_nxt;
    pend_off_r <= pend_off_nxt;
    best_r     <= best_nxt;
    max_r      <= max_nxt;
    out_rsp_r  <= out_rsp_nxt;
  end

  `FQR_ASSERT_NOW(a_occ_bound, clk, rst_n, 1'b1, occ_r <= DEPTH_CNT,
    "occupancy above queue depth")
  `FQR_ASSERT_NOW(a_scan_range, clk, rst_n, state_r == S_SCAN,
    occ_r != '0 && iss_r <= occ_r, "rotate scan on empty queue or past tail")
  `FQR_ASSERT_NOW(a_rsp_count, clk, rst_n, $rose(out_valid_r),
    out_rsp_r.entry_count == ENTRY_W'(occ_r), "response count differs from occupancy")
  `FQR_ASSERT_NOW(a_full_status, clk, rst_n, $rose(out_valid_r) && out_rsp_r.status == ST_FULL,
    occ_r == DEPTH_CNT, "full status while queue not full")
  `FQR_ASSERT_NOW(a_empty_head, clk, rst_n, out_valid_r && out_rsp_r.entry_count == '0,
    out_rsp_r.head_value == '0, "empty queue reports nonzero head")

endmodule

FILE: hw/rtl/fqrm_ram.sv
module fqrm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
